/* hdl/cpualu_pkg.sv */
package cpualu_pkg;

   localparam logic [4:0] OP_ADD      = 5'd0;
   localparam logic [4:0] OP_ADC      = 5'd1;
   localparam logic [4:0] OP_SUB      = 5'd2;
   localparam logic [4:0] OP_SBC      = 5'd3;
   localparam logic [4:0] OP_AND      = 5'd4;
   localparam logic [4:0] OP_XOR      = 5'd5;
   localparam logic [4:0] OP_OR       = 5'd6;
   localparam logic [4:0] OP_INC8     = 5'd7;
   localparam logic [4:0] OP_DEC8     = 5'd8;
   localparam logic [4:0] OP_RLC      = 5'd9;
   localparam logic [4:0] OP_RRC      = 5'd10;
   localparam logic [4:0] OP_RL       = 5'd11;
   localparam logic [4:0] OP_RR       = 5'd12;
   localparam logic [4:0] OP_SLA      = 5'd13;
   localparam logic [4:0] OP_SRA      = 5'd14;
   localparam logic [4:0] OP_SWAP     = 5'd15;
   localparam logic [4:0] OP_SRL      = 5'd16;
   localparam logic [4:0] OP_BIT      = 5'd17;
   localparam logic [4:0] OP_RES      = 5'd18;
   localparam logic [4:0] OP_SET      = 5'd19;
   localparam logic [4:0] OP_DAA      = 5'd20;
   localparam logic [4:0] OP_ADD16    = 5'd21;
   localparam logic [4:0] OP_ADD16_S8 = 5'd22;
   localparam logic [4:0] OP_INC16    = 5'd23;
   localparam logic [4:0] OP_DEC16    = 5'd24;

   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   localparam logic [3:0] DAA_DIGIT_LIMIT = 4'h9;
   localparam logic [7:0] DAA_BYTE_LIMIT  = 8'h99;
   localparam logic [3:0] DAA_ADJUST      = 4'h6;

   typedef struct packed {
      logic [4:0]  opcode;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [2:0]  bit_index;
      logic [3:0]  flags_in;
   } req_type;

   typedef struct packed {
      logic [15:0] result;
      logic [3:0]  flags_out;
   } rsp_type;

endpackage

/* hdl/cpualu_core.sv */
module cpualu_core (
   input  cpualu_pkg::req_type req,
   output cpualu_pkg::rsp_type rsp
);

   always_comb begin
      logic [7:0]  a;
      logic [7:0]  b;
      logic        c_in;
      logic        cx;
      logic        n_in;
      logic        hi_adj;
      logic [8:0]  sum9;
      logic [4:0]  h5;
      logic [7:0]  r8;
      logic [7:0]  adj;
      logic [7:0]  mask;
      logic [12:0] sum13;
      logic [16:0] sum17;
      logic [15:0] r16;
      logic [3:0]  f;

      a      = req.operand_a[7:0];
      b      = req.operand_b[7:0];
      c_in   = req.flags_in[cpualu_pkg::FLAG_C];
      n_in   = req.flags_in[cpualu_pkg::FLAG_N];
      cx     = 1'b0;
      hi_adj = 1'b0;
      sum9   = '0;
      h5     = '0;
      r8     = '0;
      adj    = '0;
      sum13  = '0;
      sum17  = '0;
      mask   = 8'b1 << req.bit_index;
      r16    = req.operand_a;
      f      = req.flags_in;

      case (req.opcode)
         cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADC: begin
            cx   = (req.opcode == cpualu_pkg::OP_ADC) && c_in;
            sum9 = {1'b0, a} + {1'b0, b} + {8'b0, cx};
            h5   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cx};
            r8   = sum9[7:0];
            f    = {r8 == 8'h00, 1'b0, h5[4], sum9[8]};
            r16  = {8'h00, r8};
         end
         cpualu_pkg::OP_SUB, cpualu_pkg::OP_SBC: begin
            cx   = (req.opcode == cpualu_pkg::OP_SBC) && c_in;
            sum9 = {1'b0, a} - {1'b0, b} - {8'b0, cx};
            h5   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, cx};
            r8   = sum9[7:0];
            f    = {r8 == 8'h00, 1'b1, h5[4], sum9[8]};
            r16  = {8'h00, r8};
         end
         cpualu_pkg::OP_AND: begin
            r8  = a & b;
            f   = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
            r16 = {8'h00, r8};
         end
         cpualu_pkg::OP_XOR: begin
            r8  = a ^ b;
            f   = {r8 == 8'h00, 3'b000};
            r16 = {8'h00, r8};
         end
         cpualu_pkg::OP_OR: begin
            r8  = a | b;
            f   = {r8 == 8'h00, 3'b000};
            r16 = {8'h00, r8};
         end
         cpualu_pkg::OP_INC8: begin
            r8  = a + 8'd1;
            f   = {r8 == 8'h00, 1'b0, r8[3:0] == 4'h0, c_in};
            r16 = {8'h00, r8};
         end
         cpualu_pkg::OP_DEC8: begin
            r8  = a - 8'd1;
            f   = {r8 == 8'h00, 1'b1, r8[3:0] == 4'hF, c_in};
            r16 = {8'h00, r8};
         end
         cpualu_pkg::OP_RLC: begin
            r8  = {a[6:0], a[7]};
            f   = {r8 == 8'h00, 2'b00, a[7]};
            r16 = {8'h00, r8};
         end
         cpualu_pkg::OP_RL: begin
            r8  = {a[6:0], c_in};
            f   = {r8 == 8'h00, 2'b00, a[7]};
            r16 = {8'h00, r8};
         end
         cpualu_pkg::OP_SLA: begin
            r8  = {a[6:0], 1'b0};
            f   = {r8 == 8'h00, 2'b00, a[7]};
            r16 = {8'h00, r8};
         end
         cpualu_pkg::OP_RRC: begin
            r8  = {a[0], a[7:1]};
            f   = {r8 == 8'h00, 2'b00, a[0]};
            r16 = {8'h00, r8};
         end
         cpualu_pkg::OP_RR: begin
            r8  = {c_in, a[7:1]};
            f   = {r8 == 8'h00, 2'b00, a[0]};
            r16 = {8'h00, r8};
         end
         cpualu_pkg::OP_SRA: begin
            r8  = {a[7], a[7:1]};
            f   = {r8 == 8'h00, 2'b00, a[0]};
            r16 = {8'h00, r8};
         end
         cpualu_pkg::OP_SRL: begin
            r8  = {1'b0, a[7:1]};
            f   = {r8 == 8'h00, 2'b00, a[0]};
            r16 = {8'h00, r8};
         end
         cpualu_pkg::OP_SWAP: begin
            r8  = {a[3:0], a[7:4]};
            f   = {r8 == 8'h00, 3'b000};
            r16 = {8'h00, r8};
         end
         cpualu_pkg::OP_BIT: begin
            f = {(a & mask) == 8'h00, 1'b0, 1'b1, c_in};
         end
         cpualu_pkg::OP_RES: begin
            r8  = a & ~mask;
            r16 = {8'h00, r8};
         end
         cpualu_pkg::OP_SET: begin
            r8  = a | mask;
            r16 = {8'h00, r8};
         end
         cpualu_pkg::OP_DAA: begin
            if ((!n_in && (a[3:0] > cpualu_pkg::DAA_DIGIT_LIMIT))
                  || req.flags_in[cpualu_pkg::FLAG_H]) begin
               adj[3:0] = cpualu_pkg::DAA_ADJUST;
            end
            hi_adj = (!n_in && (a > cpualu_pkg::DAA_BYTE_LIMIT)) || c_in;
            if (hi_adj) begin
               adj[7:4] = cpualu_pkg::DAA_ADJUST;
            end
            r8  = n_in ? (a - adj) : (a + adj);
            f   = {r8 == 8'h00, n_in, 1'b0, hi_adj};
            r16 = {8'h00, r8};
         end
         cpualu_pkg::OP_ADD16: begin
            sum17 = {1'b0, req.operand_a} + {1'b0, req.operand_b};
            sum13 = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
            r16   = sum17[15:0];
            f     = {req.flags_in[cpualu_pkg::FLAG_Z], 1'b0, sum13[12], sum17[16]};
         end
         cpualu_pkg::OP_ADD16_S8: begin
            sum9 = {1'b0, a} + {1'b0, b};
            h5   = {1'b0, a[3:0]} + {1'b0, b[3:0]};
            r16  = req.operand_a + {{8{b[7]}}, b};
            f    = {2'b00, h5[4], sum9[8]};
         end
         cpualu_pkg::OP_INC16: begin
            r16 = req.operand_a + 16'd1;
         end
         cpualu_pkg::OP_DEC16: begin
            r16 = req.operand_a - 16'd1;
         end
         default: begin
            r16 = req.operand_a;
         end
      endcase

      rsp.result    = r16;
      rsp.flags_out = f;
   end

endmodule

/* hdl/cpu_alu_8bit_flags.sv */
// 8-bit ALU with 16-bit add and inc/dec; zero, subtract, half-carry and carry flags.
// An accepted item passes the input register, then the result register, and shows on
// rsp_data with rsp_valid for one cycle.
// Throughput: one item per cycle; busy is never raised and the receiver cannot stall.
// Reset is synchronous and active high; it clears the valid flags of both stages.
module cpu_alu_8bit_flags (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  cpualu_pkg::req_type req_data,
   output logic                rsp_valid,
   output cpualu_pkg::rsp_type rsp_data
);

   logic                in_valid_ff;
   logic                in_valid_in;
   cpualu_pkg::req_type req_ff;
   cpualu_pkg::req_type req_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   cpualu_pkg::rsp_type rsp_ff;
   cpualu_pkg::rsp_type rsp_in;

   assign busy         = 1'b0;
   assign in_valid_in  = start && !busy;
   assign req_in       = req_data;
   assign rsp_valid_in = in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   cpualu_core u_core (
      .req (req_ff),
      .rsp (rsp_in)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_two_cycle_latency: assert property (
      @(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid
   ) else $error("accepted item did not produce a result two cycles later");

   a_no_spurious_result: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2)
   ) else $error("result strobe without an accepted item");

   a_s8_flags: assert property (
      @(posedge clock) disable iff (reset)
      (in_valid_ff && (req_ff.opcode == cpualu_pkg::OP_ADD16_S8))
         |=> (rsp_data.flags_out[cpualu_pkg::FLAG_Z] == 1'b0)
             && (rsp_data.flags_out[cpualu_pkg::FLAG_N] == 1'b0)
   ) else $error("16-bit plus offset left Z or N set");

   a_inc16_flags: assert property (
      @(posedge clock) disable iff (reset)
      (in_valid_ff && (req_ff.opcode == cpualu_pkg::OP_INC16))
         |=> (rsp_data.flags_out == $past(req_ff.flags_in))
   ) else $error("16-bit increment changed the flags");

endmodule
